/* hdl/tactile_grasp_controller_top_macros.svh */
// Assertion macros for the tactile grasp controller.
// Each macro takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef TACTILE_GRASP_CONTROLLER_TOP_MACROS_SVH
`define TACTILE_GRASP_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define TGC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgc: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define TGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgc: next-cycle check failed");
`else
`define TGC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TGC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/tgc_pkg.sv */
package tgc_pkg;

    // Field widths.
    localparam int CMD_W      = 3;
    localparam int PAD_W      = 3;
    localparam int CELL_W     = 12;
    localparam int JOINT_W    = 3;
    localparam int ANGLE_W    = 16;
    localparam int THR_W      = 12;
    localparam int GAIN_W     = 10;
    localparam int VEL_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Accumulator and mean widths.
    localparam int SUM_W      = 19;
    localparam int CNT_W      = 8;
    localparam int MEAN_W     = 12;
    localparam int ERR_W      = 16;
    localparam int PAIR_W     = MEAN_W + 1;
    localparam int TOTAL_W    = MEAN_W + 3;
    localparam int PROX_W     = MEAN_W + 2;

    // Sizes and limits.
    localparam int MAX_CELLS   = 128;
    localparam int PAD_COUNT   = 6;
    localparam int JOINT_COUNT = 7;
    localparam int LIM_COUNT   = 3;
    localparam int PROX_LIMIT  = 10;
    localparam int TOTAL_LIMIT = 2000;

    localparam logic [SUM_W-1:0]        SUM_MAX  = {SUM_W{1'b1}};
    localparam logic signed [ANGLE_W-1:0] ANGLE_HI = 16'sd8700;
    localparam logic signed [ANGLE_W-1:0] ANGLE_LO = -16'sd8700;
    localparam logic signed [ERR_W-1:0]   LVL_ZERO_THRESH = -16'sd2;

    // The mean always fits in MEAN_W bits, so the divider retires that many quotient bits.
    localparam int DIV_STEPS  = MEAN_W;
    localparam int DIV_STEP_W = 4;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THR_LAST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_APPROACH = 3'd7;

    // Register reset values.
    localparam logic [THR_W-1:0]  THR_RESET      = 12'd100;
    localparam logic [GAIN_W-1:0] GAIN_RESET     = 10'd300;
    localparam logic [THR_W-1:0]  APPROACH_RESET = 12'd20;

    typedef enum logic [CMD_W-1:0] {
        CMD_CELL  = 3'd0,
        CMD_JOINT = 3'd1,
        CMD_GRASP = 3'd2,
        CMD_OPEN  = 3'd3,
        CMD_TRAJ  = 3'd4
    } cmd_code_t;

    // Input transaction payload.
    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [PAD_W-1:0]          pad;
        logic [CELL_W-1:0]         cell_value;
        logic                      last_in_pad;
        logic [JOINT_W-1:0]        joint_index;
        logic signed [ANGLE_W-1:0] joint_angle;
        logic                      lateral;
    } tgc_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accumulate;
        logic div_start;
        logic joint;
        logic grasp;
        logic open_hand;
        logic frame_eval;
        logic emit_vel;
        logic emit_backoff;
    } tgc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pad_end;
        logic frame_end;
        logic div_done;
        logic hand_open;
        logic backoff;
        logic traj_over;
        logic out_free;
    } tgc_sts_t;

endpackage

/* hdl/tgc_if.sv */
// Input channel: one transaction per tactile cell or event.
interface tgc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [tgc_pkg::CMD_W-1:0]              command;
    logic [tgc_pkg::PAD_W-1:0]              pad;
    logic [tgc_pkg::CELL_W-1:0]             cell_value;
    logic                                   last_in_pad;
    logic [tgc_pkg::JOINT_W-1:0]            joint_index;
    logic signed [tgc_pkg::ANGLE_W-1:0]     joint_angle;
    logic                                   lateral;

    modport source (
        output valid, command, pad, cell_value, last_in_pad, joint_index, joint_angle, lateral,
        input  ready
    );
    modport sink (
        input  valid, command, pad, cell_value, last_in_pad, joint_index, joint_angle, lateral,
        output ready
    );
endinterface

// Output channel: one velocity or backoff command per transaction.
interface tgc_out_if;
    logic                       valid;
    logic                       ready;
    logic [tgc_pkg::VEL_W-1:0]  vel_0;
    logic [tgc_pkg::VEL_W-1:0]  vel_1;
    logic [tgc_pkg::VEL_W-1:0]  vel_2;
    logic [tgc_pkg::VEL_W-1:0]  vel_3;
    logic [tgc_pkg::VEL_W-1:0]  vel_4;
    logic [tgc_pkg::VEL_W-1:0]  vel_5;
    logic                       velocity_valid;
    logic                       backoff_request;

    modport source (
        output valid, vel_0, vel_1, vel_2, vel_3, vel_4, vel_5, velocity_valid,
               backoff_request,
        input  ready
    );
    modport sink (
        input  valid, vel_0, vel_1, vel_2, vel_3, vel_4, vel_5, velocity_valid,
               backoff_request,
        output ready
    );
endinterface

/* hdl/tgc_div.sv */
`include "tactile_grasp_controller_top_macros.svh"

module tgc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tgc_pkg::SUM_W-1:0]   dividend,
    input  logic [tgc_pkg::CNT_W-1:0]   divisor,
    output logic                        done,
    output logic [tgc_pkg::MEAN_W-1:0]  quotient
);
    import tgc_pkg::*;

    logic                   busy_reg;
    logic [DIV_STEP_W-1:0]  step_reg;
    logic [CNT_W-1:0]       rem_reg;
    logic [MEAN_W-1:0]      quo_reg;
    logic [CNT_W-1:0]       den_reg;
    logic                   zero_reg;

    logic [CNT_W:0]         shifted;
    logic [CNT_W:0]         trial;
    logic                   fits;
    logic [CNT_W-1:0]       rem_next;
    logic [MEAN_W-1:0]      quo_next;

    // One restoring step: bring down the next dividend bit and try the subtraction.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[MEAN_W-1]};
        trial    = shifted - {1'b0, den_reg};
        fits     = !trial[CNT_W];
        rem_next = fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
        quo_next = {quo_reg[MEAN_W-2:0], fits};
    end

    assign done     = busy_reg && (step_reg == DIV_STEP_W'(DIV_STEPS - 1));
    assign quotient = zero_reg ? '0 : quo_next;

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    // The mean never exceeds the cell range, so the upper dividend bits start in the remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= CNT_W'(dividend[SUM_W-1:MEAN_W]);
            quo_reg  <= dividend[MEAN_W-1:0];
            den_reg  <= divisor;
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    `TGC_ASSERT_NEXT(a_done_ends_busy, clk, rst_n, done && !start, !busy_reg)
    `TGC_ASSERT_IMPL(a_start_when_free, clk, rst_n, start, !busy_reg)

endmodule

/* hdl/tgc_dp.sv */
`include "tactile_grasp_controller_top_macros.svh"

module tgc_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tgc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  tgc_pkg::tgc_item_t              item,
    input  tgc_pkg::tgc_cmd_t               cmd,
    output tgc_pkg::tgc_sts_t               sts,
    tgc_out_if.source                       result
);
    import tgc_pkg::*;

    // Configuration registers.
    logic [THR_W-1:0]   thr_reg [PAD_COUNT];
    logic [GAIN_W-1:0]  gain_reg;
    logic [THR_W-1:0]   appr_reg;

    // Pad accumulator and stored means.
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]   sum_acc;
    logic [CNT_W-1:0]   cnt_acc;
    logic [SUM_W:0]     sum_wide;
    logic               can_add;
    logic [PAD_W-1:0]   pad_reg;
    logic [MEAN_W-1:0]  mean_reg [PAD_COUNT];
    logic               div_done;
    logic [MEAN_W-1:0]  div_quot;

    // Hand state.
    logic               grip_reg;
    logic               hand_open_reg;
    logic               prox_only_reg;
    logic               lim_reg [LIM_COUNT];
    logic               backoff_reg;
    logic               backoff_now;
    logic               distal_hit;
    logic               prox_hit;
    logic [PROX_W-1:0]  prox_sum;

    // Error sums and the totals for trajectory checks.
    logic signed [ERR_W-1:0] sp_calc;
    logic signed [ERR_W-1:0] sd_calc;
    logic signed [ERR_W-1:0] sp_reg;
    logic signed [ERR_W-1:0] sd_reg;
    logic signed [ERR_W-1:0] lvl_thresh;
    logic [ERR_W-1:0]        three_lvl;
    logic                    ge_p;
    logic                    ge_d;
    logic [PAIR_W-1:0]       pair_reg [LIM_COUNT];
    logic [TOTAL_W-1:0]      total;

    // Velocity result and output register.
    logic [VEL_W-1:0]   vel_calc [PAD_COUNT];
    logic [VEL_W-1:0]   vel_reg [PAD_COUNT];
    logic               vv_reg;
    logic               bo_reg;
    logic               out_valid_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAD_COUNT; i++)
            begin
                thr_reg[i] <= THR_RESET;
            end
            gain_reg <= GAIN_RESET;
            appr_reg <= APPROACH_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index <= CFG_THR_LAST)
            begin
                thr_reg[cfg_index] <= cfg_data[THR_W-1:0];
            end
            else if (cfg_index == CFG_GAIN)
            begin
                gain_reg <= cfg_data[GAIN_W-1:0];
            end
            else if (cfg_index == CFG_APPROACH)
            begin
                appr_reg <= cfg_data[THR_W-1:0];
            end
        end
    end

    // Add a nonzero cell while the pad has room, saturating the sum.
    always_comb
    begin
        can_add  = (item.cell_value != '0) && (cnt_reg < CNT_W'(MAX_CELLS));
        sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(item.cell_value);
        sum_acc  = sum_reg;
        cnt_acc  = cnt_reg;
        if (can_add)
        begin
            sum_acc = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            cnt_acc = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.accumulate)
        begin
            if (item.last_in_pad)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_acc;
                cnt_reg <= cnt_acc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            pad_reg <= item.pad;
        end
    end

    tgc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_acc),
        .divisor  (cnt_acc),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Store the pad mean when the divider finishes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAD_COUNT; i++)
            begin
                mean_reg[i] <= '0;
            end
        end
        else if (div_done)
        begin
            mean_reg[pad_reg] <= div_quot;
        end
    end

    // Contact checks at frame end.
    always_comb
    begin
        distal_hit  = (mean_reg[1] > thr_reg[1]) && (mean_reg[3] > thr_reg[3])
                      && (mean_reg[5] > thr_reg[5]);
        prox_sum    = PROX_W'(mean_reg[0]) + PROX_W'(mean_reg[2]) + PROX_W'(mean_reg[4]);
        prox_hit    = (prox_sum > PROX_W'(PROX_LIMIT)) && prox_only_reg;
        backoff_now = distal_hit || prox_hit;
    end

    // Threshold error sums of the proximal and distal pad groups.
    always_comb
    begin
        sp_calc = $signed(ERR_W'(thr_reg[0])) - $signed(ERR_W'(mean_reg[0]))
                + $signed(ERR_W'(thr_reg[2])) - $signed(ERR_W'(mean_reg[2]))
                + $signed(ERR_W'(thr_reg[4])) - $signed(ERR_W'(mean_reg[4]));
        sd_calc = $signed(ERR_W'(thr_reg[1])) - $signed(ERR_W'(mean_reg[1]))
                + $signed(ERR_W'(thr_reg[3])) - $signed(ERR_W'(mean_reg[3]))
                + $signed(ERR_W'(thr_reg[5])) - $signed(ERR_W'(mean_reg[5]));
    end

    // Hand state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grip_reg      <= 1'b0;
            hand_open_reg <= 1'b1;
            prox_only_reg <= 1'b1;
            backoff_reg   <= 1'b0;
        end
        else if (cmd.grasp)
        begin
            grip_reg      <= 1'b1;
            hand_open_reg <= 1'b0;
            if (item.lateral)
            begin
                prox_only_reg <= 1'b0;
            end
        end
        else if (cmd.open_hand)
        begin
            grip_reg      <= 1'b0;
            hand_open_reg <= 1'b1;
            prox_only_reg <= 1'b1;
        end
        else if (cmd.frame_eval)
        begin
            backoff_reg <= backoff_now;
            if (backoff_now)
            begin
                grip_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.frame_eval)
        begin
            sp_reg <= sp_calc;
            sd_reg <= sd_calc;
        end
    end

    // Out-of-range flags of joints 1, 3 and 5; saturation cannot change the comparison.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIM_COUNT; i++)
            begin
                lim_reg[i] <= 1'b0;
            end
        end
        else if (cmd.joint && item.joint_index[0]
                 && (item.joint_index < JOINT_W'(JOINT_COUNT)))
        begin
            lim_reg[item.joint_index[2:1]] <= (item.joint_angle < ANGLE_LO)
                                            || (item.joint_angle > ANGLE_HI);
        end
    end

    // The truncated third of a sum reaches the level exactly when the sum reaches three times
    // the level; for a zero level a sum above minus three still truncates to zero.
    always_comb
    begin
        three_lvl  = ERR_W'(appr_reg) + ERR_W'({appr_reg, 1'b0});
        lvl_thresh = (appr_reg == '0) ? LVL_ZERO_THRESH : $signed(three_lvl);
        ge_p       = sp_reg >= lvl_thresh;
        ge_d       = sd_reg >= lvl_thresh;
        for (int i = 0; i < LIM_COUNT; i++)
        begin
            vel_calc[2*i]   = (grip_reg && ge_p) ? gain_reg : '0;
            vel_calc[2*i+1] = (grip_reg && !prox_only_reg && ge_d && !lim_reg[i])
                              ? gain_reg : '0;
        end
    end

    // Pairwise mean sums for the trajectory total.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LIM_COUNT; i++)
        begin
            pair_reg[i] <= PAIR_W'(mean_reg[2*i]) + PAIR_W'(mean_reg[2*i+1]);
        end
    end

    assign total = TOTAL_W'(pair_reg[0]) + TOTAL_W'(pair_reg[1]) + TOTAL_W'(pair_reg[2]);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_vel || cmd.emit_backoff)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_vel)
        begin
            for (int i = 0; i < PAD_COUNT; i++)
            begin
                vel_reg[i] <= vel_calc[i];
            end
            vv_reg <= 1'b1;
            bo_reg <= backoff_reg;
        end
        else if (cmd.emit_backoff)
        begin
            for (int i = 0; i < PAD_COUNT; i++)
            begin
                vel_reg[i] <= '0;
            end
            vv_reg <= 1'b0;
            bo_reg <= 1'b1;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.vel_0           = vel_reg[0];
    assign result.vel_1           = vel_reg[1];
    assign result.vel_2           = vel_reg[2];
    assign result.vel_3           = vel_reg[3];
    assign result.vel_4           = vel_reg[4];
    assign result.vel_5           = vel_reg[5];
    assign result.velocity_valid  = vv_reg;
    assign result.backoff_request = bo_reg;

    // Status to the controller.
    always_comb
    begin
        sts.pad_end   = item.last_in_pad && (item.pad < PAD_W'(PAD_COUNT));
        sts.frame_end = (pad_reg == PAD_W'(PAD_COUNT - 1));
        sts.div_done  = div_done;
        sts.hand_open = hand_open_reg;
        sts.backoff   = backoff_reg;
        sts.traj_over = total > TOTAL_W'(TOTAL_LIMIT);
        sts.out_free  = !out_valid_reg || result.ready;
    end

    `TGC_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(MAX_CELLS))
    `TGC_ASSERT_NEXT(a_emit_loads_output, clk, rst_n, cmd.emit_vel || cmd.emit_backoff, out_valid_reg)

endmodule

/* hdl/tgc_ctrl.sv */
`include "tactile_grasp_controller_top_macros.svh"

module tgc_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic [tgc_pkg::CMD_W-1:0]   item_command,
    output logic                        item_ready,
    output tgc_pkg::tgc_cmd_t           cmd,
    input  tgc_pkg::tgc_sts_t           sts
);
    import tgc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_DIV     = 6'b000010,
        ST_FRAME   = 6'b000100,
        ST_VEL     = 6'b001000,
        ST_TRAJ    = 6'b010000,
        ST_BACKOFF = 6'b100000
    } tgc_state_t;

    tgc_state_t state_reg;
    tgc_state_t state_next;

    // Next state and commands to the datapath.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (cmd_code_t'(item_command))
                        CMD_CELL:
                        begin
                            cmd.accumulate = 1'b1;
                            if (sts.pad_end)
                            begin
                                cmd.div_start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                        CMD_JOINT: cmd.joint     = 1'b1;
                        CMD_GRASP: cmd.grasp     = 1'b1;
                        CMD_OPEN:  cmd.open_hand = 1'b1;
                        CMD_TRAJ:  state_next    = ST_TRAJ;
                        default:   ;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = sts.frame_end ? ST_FRAME : ST_IDLE;
                end
            end
            ST_FRAME:
            begin
                cmd.frame_eval = 1'b1;
                state_next     = ST_VEL;
            end
            ST_VEL:
            begin
                if (!sts.hand_open)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit_vel = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = sts.backoff ? ST_BACKOFF : ST_IDLE;
                end
            end
            ST_TRAJ:
            begin
                state_next = sts.traj_over ? ST_BACKOFF : ST_IDLE;
            end
            ST_BACKOFF:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_backoff = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `TGC_ASSERT_IMPL(a_emit_needs_room, clk, rst_n, cmd.emit_vel || cmd.emit_backoff, sts.out_free)
    `TGC_ASSERT_IMPL(a_div_from_accept, clk, rst_n, cmd.div_start, item_valid && item_ready)
    `TGC_ASSERT_NEXT(a_div_enters_wait, clk, rst_n, cmd.div_start, state_reg == ST_DIV)

endmodule

/* hdl/tactile_grasp_controller_top.sv */
// Joint, grasp, open-hand, unknown and non-final cell transactions run back to back. The final
// cell of a pad waits for the divider that forms the mean one quotient bit per cycle; the
// frame's final cell then passes the frame and velocity states (and the backoff state when an
// open hand backs off) into the output register. Trajectory done passes the trajectory state,
// and backoff when it backs off. A result that cannot enter a full output register stalls input.
// Asynchronous active-low reset loads register defaults, clears the means and opens the hand.
module tactile_grasp_controller_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tgc_pkg::CFG_DATA_W-1:0]  cfg_data,
    tgc_in_if.sink                          item,
    tgc_out_if.source                       result
);
    import tgc_pkg::*;

    tgc_item_t item_data;
    tgc_cmd_t  cmd;
    tgc_sts_t  sts;
    logic      ready;

    // Gather the input payload for the datapath.
    always_comb
    begin
        item_data.command     = item.command;
        item_data.pad         = item.pad;
        item_data.cell_value  = item.cell_value;
        item_data.last_in_pad = item.last_in_pad;
        item_data.joint_index = item.joint_index;
        item_data.joint_angle = item.joint_angle;
        item_data.lateral     = item.lateral;
    end

    assign item.ready = ready;

    tgc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_command (item.command),
        .item_ready   (ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    tgc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_data),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

endmodule

/* verif/tactile_grasp_controller_top_tb.sv */
`timescale 1ns / 1ps

module tactile_grasp_controller_top_tb;
    import tgc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 185;
    localparam int GAIN_MAX       = 1000;
    localparam int CELL_MAX       = 4095;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_FIRST    = 3'd0;
    localparam logic [CMD_W-1:0]     CMD_FIRST_UNUSED = 3'd5;

    // One velocity or backoff command as the hand should receive it.
    typedef struct packed {
        logic [5:0][VEL_W-1:0] vel;
        logic                  velocity_valid;
        logic                  backoff_request;
    } hand_cmd_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tgc_in_if  item_if ();
    tgc_out_if result_if ();

    tactile_grasp_controller_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_if),
        .result    (result_if)
    );

    // Register copies and controller state, kept in step with the block.
    logic [THR_W-1:0]  thr [PAD_COUNT];
    logic [GAIN_W-1:0] gain;
    logic [THR_W-1:0]  approach;
    logic [SUM_W-1:0]  acc_sum;
    logic [CNT_W-1:0]  acc_cnt;
    logic [MEAN_W-1:0] pad_avg [PAD_COUNT];
    int                joint_pos [JOINT_COUNT];
    bit                gripping;
    bit                hand_is_open;
    bit                prox_only;

    hand_cmd_t expected_hand_cmds [$];
    int        fail_count;
    int        items_sent;
    int        send_gap_pct;
    int        stall_pct;
    int        hold_left;
    int        quiet_cycles;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the controller state by one accepted transaction and queue any command it causes.
    function automatic void update_grasp_state(tgc_item_t it);
        int        s;
        int        m;
        int        a;
        int        ep;
        int        ed;
        int        total;
        bit        backoff;
        hand_cmd_t c;
        c = '0;
        case (it.command)
            CMD_CELL:
            begin
                if (it.cell_value != 0 && acc_cnt < MAX_CELLS)
                begin
                    s = int'(acc_sum) + int'(it.cell_value);
                    acc_sum = (s > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(s);
                    acc_cnt = acc_cnt + 1'b1;
                end
                if (it.last_in_pad)
                begin
                    m = (acc_cnt != 0) ? int'(acc_sum / acc_cnt) : 0;
                    acc_sum = '0;
                    acc_cnt = '0;
                    if (it.pad < PAD_COUNT)
                    begin
                        pad_avg[it.pad] = MEAN_W'(m);
                        // The last pad closes the frame: contact checks, then the velocity rule.
                        if (it.pad == PAD_COUNT - 1)
                        begin
                            backoff = 1'b0;
                            if (pad_avg[1] > thr[1] && pad_avg[3] > thr[3]
                                && pad_avg[5] > thr[5])
                            begin
                                gripping = 1'b0;
                                backoff = 1'b1;
                            end
                            if (int'(pad_avg[0]) + int'(pad_avg[2]) + int'(pad_avg[4])
                                > PROX_LIMIT && prox_only)
                            begin
                                gripping = 1'b0;
                                backoff = 1'b1;
                            end
                            if (!hand_is_open)
                            begin
                                if (gripping)
                                begin
                                    ep = (int'(thr[0]) - int'(pad_avg[0]) + int'(thr[2])
                                          - int'(pad_avg[2]) + int'(thr[4]) - int'(pad_avg[4])) / 3;
                                    ed = (int'(thr[1]) - int'(pad_avg[1]) + int'(thr[3])
                                          - int'(pad_avg[3]) + int'(thr[5]) - int'(pad_avg[5])) / 3;
                                    for (int k = 0; k < 6; k += 2)
                                    begin
                                        if (ep >= int'(approach))
                                            c.vel[k] = gain;
                                        if (!prox_only && ed >= int'(approach))
                                            c.vel[k + 1] = gain;
                                    end
                                    // Distal channels stop when their joint is past the limit.
                                    for (int k = 1; k < 6; k += 2)
                                        if (joint_pos[k] < int'(ANGLE_LO)
                                            || joint_pos[k] > int'(ANGLE_HI))
                                            c.vel[k] = '0;
                                end
                                c.velocity_valid = 1'b1;
                                c.backoff_request = backoff;
                                expected_hand_cmds = {expected_hand_cmds, c};
                            end
                            else if (backoff)
                            begin
                                c.backoff_request = 1'b1;
                                expected_hand_cmds = {expected_hand_cmds, c};
                            end
                        end
                    end
                end
            end
            CMD_JOINT:
            begin
                if (it.joint_index < JOINT_COUNT)
                begin
                    a = int'($signed(it.joint_angle));
                    if (a > 16383)
                        a = 16383;
                    if (a < -16384)
                        a = -16384;
                    joint_pos[it.joint_index] = a;
                end
            end
            CMD_GRASP:
            begin
                gripping = 1'b1;
                hand_is_open = 1'b0;
                if (it.lateral)
                    prox_only = 1'b0;
            end
            CMD_OPEN:
            begin
                hand_is_open = 1'b1;
                gripping = 1'b0;
                prox_only = 1'b1;
            end
            CMD_TRAJ:
            begin
                total = 0;
                for (int k = 0; k < PAD_COUNT; k++)
                    total += int'(pad_avg[k]);
                if (total > TOTAL_LIMIT)
                begin
                    c.backoff_request = 1'b1;
                    expected_hand_cmds = {expected_hand_cmds, c};
                end
            end
            default:
                ;
        endcase
    endfunction

    // A transaction with every field random except the command.
    function automatic tgc_item_t random_payload(logic [CMD_W-1:0] cmd);
        tgc_item_t it;
        it.command     = cmd;
        it.pad         = PAD_W'($urandom_range(0, 7));
        it.cell_value  = CELL_W'($urandom_range(0, CELL_MAX));
        it.last_in_pad = 1'($urandom_range(0, 1));
        it.joint_index = JOINT_W'($urandom_range(0, 7));
        it.joint_angle = ANGLE_W'($urandom);
        it.lateral     = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Cell value drawn around a level chosen per pad.
    function automatic logic [CELL_W-1:0] pick_cell(int p, int mode);
        int v;
        case (mode)
            0: v = 0;
            1: v = $urandom_range(0, 15);
            2:
            begin
                v = int'(thr[p]) + int'($urandom_range(0, 60)) - 30;
                if (v < 0)
                    v = 0;
                if (v > CELL_MAX)
                    v = CELL_MAX;
            end
            default: v = $urandom_range(0, CELL_MAX);
        endcase
        return CELL_W'(v);
    endfunction

    // Offer one transaction, idling first as the current phase asks, and wait for acceptance.
    task automatic send_item(input tgc_item_t it);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid       <= 1'b1;
        item_if.command     <= it.command;
        item_if.pad         <= it.pad;
        item_if.cell_value  <= it.cell_value;
        item_if.last_in_pad <= it.last_in_pad;
        item_if.joint_index <= it.joint_index;
        item_if.joint_angle <= it.joint_angle;
        item_if.lateral     <= it.lateral;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        update_grasp_state(it);
        items_sent++;
        @(negedge clk);
    endtask

    // One scan of all six pads; with breaks allowed a pad may be skipped, misnumbered or merged.
    task automatic send_frame(input bit allow_breaks);
        int        n;
        int        mode;
        int        brk;
        tgc_item_t it;
        for (int p = 0; p < PAD_COUNT; p++)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            mode = $urandom_range(0, 3);
            brk = (allow_breaks && $urandom_range(0, 19) == 0) ? $urandom_range(1, 3) : 0;
            if (brk == 1)
                continue;
            for (int c = 0; c < n; c++)
            begin
                it = random_payload(CMD_CELL);
                it.pad = (brk == 2) ? PAD_W'(PAD_COUNT + $urandom_range(0, 1)) : PAD_W'(p);
                it.cell_value = ($urandom_range(0, 9) == 0) ? '0 : pick_cell(p, mode);
                it.last_in_pad = (c == n - 1) && (brk != 3);
                send_item(it);
            end
        end
    endtask

    // Stop offering, wait for every expected command, then let the block go quiet.
    task automatic drain_results();
        item_if.valid <= 1'b0;
        @(negedge clk);
        while (expected_hand_cmds.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all eight registers, one per cycle.
    task automatic apply_settings(input logic [THR_W-1:0] t [PAD_COUNT], input int g,
                                  input int lvl);
        for (int p = 0; p < PAD_COUNT; p++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_THR_FIRST + CFG_IDX_W'(p);
            cfg_data  <= t[p];
            thr[p] = t[p];
            @(negedge clk);
        end
        cfg_index <= CFG_GAIN;
        cfg_data  <= CFG_DATA_W'(g);
        gain = GAIN_W'(g);
        @(negedge clk);
        cfg_index <= CFG_APPROACH;
        cfg_data  <= CFG_DATA_W'(lvl);
        approach = THR_W'(lvl);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Contact cases, joint limits, trajectory total and an unknown command at reset settings.
    task automatic test_directed_cases();
        int        levels [3][6] = '{'{0, 0, 0, 0, 0, 0}, '{20, 0, 0, 0, 0, 0},
                                     '{4095, 4095, 0, 4095, 1, 4095}};
        int        jidx [4] = '{1, 3, 5, JOINT_COUNT};
        int        jang [4] = '{8701, -32768, 8700, 32767};
        tgc_item_t it;
        send_gap_pct = 0;
        stall_pct = 0;
        // Open hand: an empty frame says nothing, a proximal touch asks for backoff.
        for (int f = 0; f < 2; f++)
            for (int p = 0; p < PAD_COUNT; p++)
            begin
                it = random_payload(CMD_CELL);
                it.pad = PAD_W'(p);
                it.cell_value = CELL_W'(levels[f][p]);
                it.last_in_pad = 1'b1;
                send_item(it);
            end
        it = random_payload(CMD_GRASP);
        it.lateral = 1'b1;
        send_item(it);
        for (int j = 0; j < 4; j++)
        begin
            it = random_payload(CMD_JOINT);
            it.joint_index = JOINT_W'(jidx[j]);
            it.joint_angle = ANGLE_W'(jang[j]);
            send_item(it);
        end
        // Distal contact on a closed hand, then a heavy trajectory total.
        for (int p = 0; p < PAD_COUNT; p++)
        begin
            it = random_payload(CMD_CELL);
            it.pad = PAD_W'(p);
            it.cell_value = CELL_W'(levels[2][p]);
            it.last_in_pad = 1'b1;
            send_item(it);
        end
        send_item(random_payload(CMD_TRAJ));
        send_item(random_payload(CMD_FIRST_UNUSED + 3'd2));
    endtask

    // A pad with more nonzero cells than the counter takes, after a discarded stray pad.
    task automatic test_cell_overflow();
        tgc_item_t it;
        send_gap_pct = 13;
        stall_pct = 13;
        send_item(random_payload(CMD_OPEN));
        it = random_payload(CMD_GRASP);
        it.lateral = 1'b1;
        send_item(it);
        it = random_payload(CMD_CELL);
        it.pad = 3'd0;
        it.cell_value = CELL_W'(CELL_MAX);
        it.last_in_pad = 1'b0;
        send_item(it);
        it = random_payload(CMD_CELL);
        it.pad = PAD_W'(PAD_COUNT + 1);
        it.last_in_pad = 1'b1;
        send_item(it);
        for (int c = 0; c < MAX_CELLS + 11; c++)
        begin
            it = random_payload(CMD_CELL);
            it.pad = 3'd0;
            it.cell_value = (c < MAX_CELLS) ? CELL_W'(CELL_MAX) : CELL_W'(c < MAX_CELLS + 10);
            it.last_in_pad = (c == MAX_CELLS + 10);
            send_item(it);
        end
        for (int p = 1; p < PAD_COUNT; p++)
        begin
            it = random_payload(CMD_CELL);
            it.pad = PAD_W'(p);
            it.cell_value = CELL_W'($urandom_range(0, 150));
            it.last_in_pad = 1'b1;
            send_item(it);
        end
    endtask

    // Random traffic over several register settings and idling patterns.
    task automatic test_random_phases();
        logic [THR_W-1:0] t [PAD_COUNT];
        int               g;
        int               lvl;
        int               start;
        int               roll;
        tgc_item_t        it;
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_results();
            for (int p = 0; p < PAD_COUNT; p++)
                case (ph)
                    0: t[p] = THR_RESET;
                    1: t[p] = '0;
                    2: t[p] = THR_W'(CELL_MAX);
                    default: t[p] = ($urandom_range(0, 1) != 0) ? THR_W'($urandom_range(0, 200))
                                                               : THR_W'($urandom_range(0, 4095));
                endcase
            case (ph)
                0:
                begin
                    g = int'(GAIN_RESET);
                    lvl = int'(APPROACH_RESET);
                end
                1:
                begin
                    g = 0;
                    lvl = 0;
                end
                2:
                begin
                    g = GAIN_MAX;
                    lvl = CELL_MAX;
                end
                default:
                begin
                    g = $urandom_range(0, GAIN_MAX);
                    lvl = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 200)
                                                      : $urandom_range(0, 4095);
                end
            endcase
            apply_settings(t, g, lvl);
            case (ph % 4)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct = 56;
                    stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct = 56;
                end
                default:
                begin
                    send_gap_pct = 13;
                    stall_pct = 13;
                end
            endcase
            start = items_sent;
            // Mostly well-formed frames, with events and stray cells mixed in.
            while (items_sent - start < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    send_frame(1'b1);
                else if (roll < 65)
                begin
                    it = random_payload(CMD_JOINT);
                    if ($urandom_range(0, 1) != 0)
                        it.joint_angle = ANGLE_W'($urandom_range(0, 18000) - 9000);
                    send_item(it);
                end
                else if (roll < 73)
                    send_item(random_payload(CMD_GRASP));
                else if (roll < 78)
                    send_item(random_payload(CMD_OPEN));
                else if (roll < 88)
                    send_item(random_payload(CMD_TRAJ));
                else if (roll < 92)
                    send_item(random_payload(CMD_FIRST_UNUSED + CMD_W'($urandom_range(0, 2))));
                else
                    send_item(random_payload(CMD_CELL));
            end
        end
    endtask

    // The receiver holds off for a long stretch while frames keep coming in.
    task automatic test_output_backpressure();
        logic [THR_W-1:0] t [PAD_COUNT];
        drain_results();
        for (int p = 0; p < PAD_COUNT; p++)
            t[p] = THR_RESET;
        apply_settings(t, int'(GAIN_RESET), int'(APPROACH_RESET));
        send_gap_pct = 0;
        stall_pct = 0;
        send_item(random_payload(CMD_GRASP));
        hold_left = HOLD_CYCLES;
        for (int f = 0; f < 6; f++)
            send_frame(1'b0);
    endtask

    // Receiver ready, with random stalls and the long hold-off counted here.
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else
                result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each accepted command with the oldest expectation.
    initial
    begin
        hand_cmd_t        want;
        logic [VEL_W-1:0] got [6];
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
            begin
                got = '{result_if.vel_0, result_if.vel_1, result_if.vel_2,
                        result_if.vel_3, result_if.vel_4, result_if.vel_5};
                if (expected_hand_cmds.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: expected nothing, actual %0d %0d %0d %0d %0d %0d %0b %0b",
                             $time, got[0], got[1], got[2], got[3], got[4], got[5],
                             result_if.velocity_valid, result_if.backoff_request);
                end
                else
                begin
                    want = expected_hand_cmds.pop_front();
                    for (int k = 0; k < 6; k++)
                        if (got[k] !== want.vel[k])
                        begin
                            fail_count++;
                            $display("%0t: vel_%0d expected %0d, actual %0d",
                                     $time, k, want.vel[k], got[k]);
                        end
                    if (result_if.velocity_valid !== want.velocity_valid)
                    begin
                        fail_count++;
                        $display("%0t: velocity_valid expected %0b, actual %0b",
                                 $time, want.velocity_valid, result_if.velocity_valid);
                    end
                    if (result_if.backoff_request !== want.backoff_request)
                    begin
                        fail_count++;
                        $display("%0t: backoff_request expected %0b, actual %0b",
                                 $time, want.backoff_request, result_if.backoff_request);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel ends the run.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)
                || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d commands outstanding",
                         $time, quiet_cycles, expected_hand_cmds.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Reset, run the tests in turn, then report.
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.command = '0;
        item_if.pad = '0;
        item_if.cell_value = '0;
        item_if.last_in_pad = 1'b0;
        item_if.joint_index = '0;
        item_if.joint_angle = '0;
        item_if.lateral = 1'b0;
        fail_count = 0;
        items_sent = 0;
        send_gap_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        for (int p = 0; p < PAD_COUNT; p++)
        begin
            thr[p] = THR_RESET;
            pad_avg[p] = '0;
        end
        gain = GAIN_RESET;
        approach = APPROACH_RESET;
        acc_sum = '0;
        acc_cnt = '0;
        for (int j = 0; j < JOINT_COUNT; j++)
            joint_pos[j] = -6000;
        gripping = 1'b0;
        hand_is_open = 1'b1;
        prox_only = 1'b1;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_cell_overflow();
        test_random_phases();
        test_output_backpressure();
        drain_results();

        if (expected_hand_cmds.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d expected commands never arrived",
                     $time, expected_hand_cmds.size());
        end
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
